/* src/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define OSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  `OSF_ASSERT(lbl, (ante) |-> (cons), msg)
`endif

/* src/osf_pkg.sv */
// Types, widths and helper functions of the overlap scoring filter.
// Used by every module of the block; depends on nothing.
package osf_pkg;
  localparam int LEN_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int ID_W    = 17;
  localparam int OS_W    = 48;
  localparam int EXT_W   = 50;
  localparam int RATIO_W = 24;
  localparam int PROD_W  = RATIO_W + LEN_W;
  localparam int WIDE_W  = 52;

  typedef enum logic [2:0] {
    V_USABLE, V_SHORT, V_CONTAINED, V_LOW_ID, V_NO_EXT, V_INVALID
  } verdict_t;

  localparam logic [2:0] CFG_RATIO     = 3'd0;
  localparam logic [2:0] CFG_MIN_ID    = 3'd1;
  localparam logic [2:0] CFG_SHORT_ON  = 3'd2;
  localparam logic [2:0] CFG_CONT_ON   = 3'd3;
  localparam logic [2:0] CFG_QUAL_ON   = 3'd4;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [ID_W-1:0]    min_id;
    logic               short_on;
    logic               cont_on;
    logic               qual_on;
  } cfg_t;

  typedef struct packed {
    logic              invalid;
    logic              sat;
    logic [LEN_W-1:0]  qoh1;
    logic [LEN_W-1:0]  qoh2;
    logic [LEN_W-1:0]  toh1;
    logic [LEN_W-1:0]  toh2;
    logic [LEN_W-1:0]  avg;
    logic [LEN_W-1:0]  alen;
    logic [LEN_W-1:0]  rem;
    logic [FRAC_W-1:0] quo;
  } rec_t;

  function automatic logic signed [WIDE_W-1:0] ext_score(
    input logic [OS_W-1:0] os, input logic [LEN_W-1:0] a,
    input logic [LEN_W-1:0] b, input logic [LEN_W-1:0] c);
    logic [LEN_W:0] bc;
    logic signed [WIDE_W-1:0] d;
    bc = {1'b0, b} + {1'b0, c};
    d = signed'({{(WIDE_W-LEN_W+1){1'b0}}, a[LEN_W-1:1]})
        - signed'({{(WIDE_W-LEN_W){1'b0}}, bc[LEN_W:1]});
    return signed'({{(WIDE_W-OS_W){1'b0}}, os}) + (d <<< FRAC_W);
  endfunction
endpackage

/* src/osf_front.sv */
// Entry stage: overhangs, aligned average, validity and divider setup.
// Depends on osf_pkg.
module osf_front import osf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [LEN_W-1:0] qlen,
  input  logic [LEN_W-1:0] qbeg,
  input  logic [LEN_W-1:0] qfin,
  input  logic [LEN_W-1:0] tlen,
  input  logic [LEN_W-1:0] tbeg,
  input  logic [LEN_W-1:0] tfin,
  input  logic             same,
  input  logic [LEN_W-1:0] match,
  input  logic [LEN_W-1:0] alen,
  output logic             dn_valid,
  output rec_t             dn_data,
  input  logic             dn_ready
);
  logic valid_r;
  rec_t data_r, data_nxt;
  logic [LEN_W-1:0] tend;
  logic [LEN_W:0] sum;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    tend = tlen - tfin;
    sum  = {1'b0, qfin - qbeg} + {1'b0, tfin - tbeg};
    data_nxt.invalid = (qbeg > qfin) || (qfin > qlen) || (tbeg > tfin) ||
                       (tfin > tlen) || (alen == '0);
    data_nxt.sat  = match >= alen;
    data_nxt.qoh1 = qbeg;
    data_nxt.qoh2 = qlen - qfin;
    data_nxt.toh1 = same ? tbeg : tend;
    data_nxt.toh2 = same ? tend : tbeg;
    data_nxt.avg  = sum[LEN_W:1];
    data_nxt.alen = alen;
    data_nxt.rem  = data_nxt.sat ? '0 : match;
    data_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

/* src/osf_div_cell.sv */
// One restoring division cell: yields one identity bit per record.
// Depends on osf_pkg.
module osf_div_cell import osf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  rec_t up_data,
  output logic dn_valid,
  output rec_t dn_data,
  input  logic dn_ready
);
  logic valid_r;
  rec_t data_r, data_nxt;
  logic [LEN_W:0] sh;
  logic ge;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    sh = {up_data.rem, 1'b0};
    ge = sh >= {1'b0, up_data.alen};
    data_nxt = up_data;
    data_nxt.rem = ge ? LEN_W'(sh - {1'b0, up_data.alen}) : sh[LEN_W-1:0];
    data_nxt.quo = {up_data.quo[FRAC_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

/* src/osf_score.sv */
// Scoring stages: products, then extension scores and classification.
// Depends on osf_pkg.
module osf_score import osf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  rec_t              up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [2:0]        verdict,
  output logic [ID_W-1:0]   identity,
  output logic [OS_W-1:0]   overlap_score,
  output logic [EXT_W-1:0]  qe_left,
  output logic [EXT_W-1:0]  qe_right,
  output logic [EXT_W-1:0]  te_left,
  output logic [EXT_W-1:0]  te_right
);
  logic a_valid_r, a_ready, b_valid_r;
  logic a_inv_r;
  logic [ID_W-1:0] a_ident_r, ident_nxt;
  logic [OS_W-1:0] a_os_r;
  logic [PROD_W-1:0] a_prod_r;
  logic [LEN_W:0] a_min_r;
  logic [LEN_W-1:0] a_qoh1_r, a_qoh2_r, a_toh1_r, a_toh2_r;
  logic [LEN_W-1:0] m1, m2;
  logic [LEN_W+ID_W-1:0] os_full;
  logic signed [WIDE_W-1:0] qe1, qe2, te1, te2;
  logic q1ge, q2ge, t1ge, t2ge, short_hit, cont_hit, low_hit, noext;
  verdict_t v_nxt;
  logic [2:0] verdict_r;
  logic [ID_W-1:0] ident_r;
  logic [OS_W-1:0] os_r;
  logic [EXT_W-1:0] qe1_r, qe2_r, te1_r, te2_r;

  assign a_ready  = !b_valid_r || dn_ready;
  assign up_ready = !a_valid_r || a_ready;
  assign dn_valid = b_valid_r;

  always_comb begin
    ident_nxt = up_data.sat ? ID_W'(1 << FRAC_W) : {1'b0, up_data.quo};
    os_full   = up_data.avg * ident_nxt;
    m1 = (up_data.qoh1 < up_data.toh1) ? up_data.qoh1 : up_data.toh1;
    m2 = (up_data.qoh2 < up_data.toh2) ? up_data.qoh2 : up_data.toh2;
  end

  always_comb begin
    q1ge = a_qoh1_r >= a_toh1_r;
    q2ge = a_qoh2_r >= a_toh2_r;
    t1ge = a_toh1_r >= a_qoh1_r;
    t2ge = a_toh2_r >= a_qoh2_r;
    qe1 = q1ge ? '0 : ext_score(a_os_r, a_toh1_r, a_qoh1_r, a_toh2_r);
    te1 = q1ge ? ext_score(a_os_r, a_qoh1_r, a_qoh2_r, a_toh1_r) : '0;
    qe2 = q2ge ? '0 : ext_score(a_os_r, a_toh2_r, a_qoh2_r, a_toh1_r);
    te2 = q2ge ? ext_score(a_os_r, a_qoh2_r, a_qoh1_r, a_toh2_r) : '0;
    short_hit = cfg.short_on &&
                ({{(PROD_W-LEN_W-1-FRAC_W){1'b0}}, a_min_r, {FRAC_W{1'b0}}} > a_prod_r);
    cont_hit  = cfg.cont_on && ((q1ge && q2ge) || (t1ge && t2ge));
    low_hit   = cfg.qual_on && (a_ident_r < cfg.min_id);
    noext     = (qe1 <= 0) && (qe2 <= 0) && (te1 <= 0) && (te2 <= 0);
    if (a_inv_r) v_nxt = V_INVALID;
    else if (short_hit) v_nxt = V_SHORT;
    else if (cont_hit) v_nxt = V_CONTAINED;
    else if (low_hit) v_nxt = V_LOW_ID;
    else if (noext) v_nxt = V_NO_EXT;
    else v_nxt = V_USABLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (up_ready) a_valid_r <= up_valid;
      if (a_ready) b_valid_r <= a_valid_r;
    end
    if (up_ready && up_valid) begin
      a_inv_r   <= up_data.invalid;
      a_ident_r <= ident_nxt;
      a_os_r    <= os_full[OS_W-1:0];
      a_prod_r  <= cfg.ratio * up_data.avg;
      a_min_r   <= {1'b0, m1} + {1'b0, m2};
      a_qoh1_r  <= up_data.qoh1;
      a_qoh2_r  <= up_data.qoh2;
      a_toh1_r  <= up_data.toh1;
      a_toh2_r  <= up_data.toh2;
    end
    if (a_ready && a_valid_r) begin
      verdict_r <= v_nxt;
      ident_r   <= a_inv_r ? '0 : a_ident_r;
      os_r      <= a_inv_r ? '0 : a_os_r;
      qe1_r     <= a_inv_r ? '0 : qe1[EXT_W-1:0];
      qe2_r     <= a_inv_r ? '0 : qe2[EXT_W-1:0];
      te1_r     <= a_inv_r ? '0 : te1[EXT_W-1:0];
      te2_r     <= a_inv_r ? '0 : te2[EXT_W-1:0];
    end
  end

  assign verdict       = verdict_r;
  assign identity      = ident_r;
  assign overlap_score = os_r;
  assign qe_left       = qe1_r;
  assign qe_right      = qe2_r;
  assign te_left       = te1_r;
  assign te_right      = te2_r;
endmodule

/* src/overlap_scoring_filter.sv */
// Overlap scoring filter, top level. An accepted transaction passes through
// one entry stage, 16 division cells and two scoring stages to its result.
// Throughput is one transaction per cycle; each stage holds its data under stall.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// Depends on osf_pkg, osf_front, osf_div_cell and osf_score.
module overlap_scoring_filter import osf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [RATIO_W-1:0]      cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [LEN_W-1:0]        in_query_length,
  input  logic [LEN_W-1:0]        in_query_begin,
  input  logic [LEN_W-1:0]        in_query_finish,
  input  logic [LEN_W-1:0]        in_target_length,
  input  logic [LEN_W-1:0]        in_target_begin,
  input  logic [LEN_W-1:0]        in_target_finish,
  input  logic                    in_same_strand,
  input  logic [LEN_W-1:0]        in_matching_bases,
  input  logic [LEN_W-1:0]        in_alignment_length,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_verdict,
  output logic [ID_W-1:0]         out_identity,
  output logic [OS_W-1:0]         out_overlap_score,
  output logic signed [EXT_W-1:0] out_query_ext_left,
  output logic signed [EXT_W-1:0] out_query_ext_right,
  output logic signed [EXT_W-1:0] out_target_ext_left,
  output logic signed [EXT_W-1:0] out_target_ext_right
);
  cfg_t cfg_r;
  logic front_ready;
  logic cv [0:FRAC_W];
  logic cr [0:FRAC_W];
  rec_t cd [0:FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio    <= RATIO_W'(19661);
      cfg_r.min_id   <= ID_W'(52429);
      cfg_r.short_on <= 1'b1;
      cfg_r.cont_on  <= 1'b1;
      cfg_r.qual_on  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATIO:    cfg_r.ratio    <= cfg_wdata;
        CFG_MIN_ID:   cfg_r.min_id   <= cfg_wdata[ID_W-1:0];
        CFG_SHORT_ON: cfg_r.short_on <= cfg_wdata[0];
        CFG_CONT_ON:  cfg_r.cont_on  <= cfg_wdata[0];
        CFG_QUAL_ON:  cfg_r.qual_on  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = !front_ready;

  osf_front u_front (
    .clk(clk), .rst_n(rst_n), .up_valid(in_valid), .up_ready(front_ready),
    .qlen(in_query_length), .qbeg(in_query_begin), .qfin(in_query_finish),
    .tlen(in_target_length), .tbeg(in_target_begin), .tfin(in_target_finish),
    .same(in_same_strand), .match(in_matching_bases), .alen(in_alignment_length),
    .dn_valid(cv[0]), .dn_data(cd[0]), .dn_ready(cr[0])
  );

  for (genvar i = 0; i < FRAC_W; i++) begin : g_cell
    osf_div_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .up_valid(cv[i]), .up_ready(cr[i]), .up_data(cd[i]),
      .dn_valid(cv[i+1]), .dn_data(cd[i+1]), .dn_ready(cr[i+1])
    );
  end

  osf_score u_score (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .up_valid(cv[FRAC_W]), .up_ready(cr[FRAC_W]), .up_data(cd[FRAC_W]),
    .dn_valid(out_valid), .dn_ready(!out_stall),
    .verdict(out_verdict), .identity(out_identity), .overlap_score(out_overlap_score),
    .qe_left(out_query_ext_left), .qe_right(out_query_ext_right),
    .te_left(out_target_ext_left), .te_right(out_target_ext_right)
  );
endmodule

/* src/osf_checker.sv */
// Port-level checker for the overlap scoring filter, bound to the top level.
// Depends on osf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module osf_checker import osf_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [2:0]              out_verdict,
  input logic [ID_W-1:0]         out_identity,
  input logic [OS_W-1:0]         out_overlap_score,
  input logic signed [EXT_W-1:0] out_query_ext_left,
  input logic signed [EXT_W-1:0] out_query_ext_right,
  input logic signed [EXT_W-1:0] out_target_ext_left,
  input logic signed [EXT_W-1:0] out_target_ext_right
);
  logic all_zero;

  assign all_zero = out_identity == '0 && out_overlap_score == '0 &&
                    out_query_ext_left == '0 && out_query_ext_right == '0 &&
                    out_target_ext_left == '0 && out_target_ext_right == '0;

  `OSF_ASSERT_IMPL(a_invalid_zero, out_valid && out_verdict == V_INVALID, all_zero, "invalid transaction carries nonzero fields")
  `OSF_ASSERT_IMPL(a_ident_max, out_valid, out_identity <= ID_W'(1 << FRAC_W), "identity above one")
  `OSF_ASSERT_IMPL(a_one_side, out_valid, out_query_ext_left == '0 || out_target_ext_left == '0, "both left extensions nonzero")
  `OSF_ASSERT_IMPL(a_hold, out_valid && out_stall, ##1 out_valid && $stable(out_verdict), "stalled result changed")
endmodule

bind overlap_scoring_filter osf_checker u_osf_checker (.*);
